>>> src/apmm_pkg.sv
// ----------------------------------------------------------------------------
// apmm_pkg
// Shared types and constants for the altitude PID and quadrotor motor mixer.
// ----------------------------------------------------------------------------
package apmm_pkg;

    // Field and datapath widths
    localparam int DATA_W     = 32;
    localparam int GAIN_W     = 40;
    localparam int ERR_W      = 33;
    localparam int SUM_W      = 48;
    localparam int SUMX_W     = SUM_W + 1;
    localparam int DIFF_W     = 34;
    localparam int MAG_W      = 48;
    localparam int MAG_HALF   = 24;
    localparam int GAIN_HALF  = 20;
    localparam int PP_W       = MAG_HALF + GAIN_HALF;
    localparam int PROD_W     = MAG_W + GAIN_W;
    localparam int FRAC_SHIFT = 24;
    localparam int QUO_W      = PROD_W - FRAC_SHIFT;
    localparam int TERM_W     = 63;
    localparam int THRUST_W   = 64;
    localparam int MIX_W      = 65;

    // Pipeline depth: error, magnitude, partial products, term, thrust, mix
    localparam int NUM_STAGES = 6;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN_DT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN_DT = 2'd2;

    // Register reset values (Q16.24): 2.5, 0.1/60, 5000/60
    localparam logic [GAIN_W-1:0] PROP_GAIN_RST     = 40'd41943040;
    localparam logic [GAIN_W-1:0] INTEG_GAIN_DT_RST = 40'd27962;
    localparam logic [GAIN_W-1:0] DERIV_GAIN_DT_RST = 40'd1398101333;

    // Saturation limits
    localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};
    localparam logic [QUO_W-1:0] TERM_LIM = QUO_W'(1) << 61;

    // Request payloads
    typedef struct packed {
        logic signed [DATA_W-1:0] measured_z;
        logic signed [DATA_W-1:0] target_z;
        logic signed [DATA_W-1:0] roll_trim;
        logic signed [DATA_W-1:0] pitch_trim;
    } sensor_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] motor_a;
        logic signed [DATA_W-1:0] motor_b;
        logic signed [DATA_W-1:0] motor_c;
        logic signed [DATA_W-1:0] motor_d;
        logic                     clipped;
    } motor_t;

    // Per-stage load enables
    typedef struct packed {
        logic err;
        logic mag;
        logic prod;
        logic term;
        logic thrust;
        logic mix;
    } stage_en_t;

    // Error stage result
    typedef struct packed {
        logic signed [ERR_W-1:0]  err;
        logic signed [SUM_W-1:0]  sum;
        logic signed [DIFF_W-1:0] diff;
        logic signed [DATA_W-1:0] roll;
        logic signed [DATA_W-1:0] pitch;
        logic                     clip;
    } err_out_t;

endpackage

>>> src/apmm_err_stage.sv
// ----------------------------------------------------------------------------
// apmm_err_stage
// Altitude error, saturating error sum and error difference; holds the
// controller state and registers the three PID operands.
// ----------------------------------------------------------------------------
module apmm_err_stage (
    input  logic                                clk,
    input  logic                                rst_n,
    input  apmm_pkg::stage_en_t                 en,
    input  logic                                accept,
    input  apmm_pkg::sensor_t                   sensor,
    output apmm_pkg::err_out_t                  stage,
    output logic signed [apmm_pkg::ERR_W-1:0]   prev_error
);
    import apmm_pkg::*;

    logic signed [SUM_W-1:0]  error_sum_reg;
    logic signed [ERR_W-1:0]  prev_error_reg;
    err_out_t                 stage_reg;
    err_out_t                 stage_next;

    logic signed [ERR_W-1:0]  err;
    logic signed [SUMX_W-1:0] sum_wide;
    logic signed [SUM_W-1:0]  sum_sat;
    logic                     sum_clip;
    logic signed [DIFF_W-1:0] diff;

    // Form error, accumulate with clamp, difference against last error
    always_comb
    begin
        err      = ERR_W'(sensor.target_z) - ERR_W'(sensor.measured_z);
        sum_wide = SUMX_W'(error_sum_reg) + SUMX_W'(err);
        sum_clip = (sum_wide[SUMX_W-1] != sum_wide[SUM_W-1]);
        if (sum_clip)
        begin
            sum_sat = sum_wide[SUMX_W-1] ? SUM_MIN : SUM_MAX;
        end
        else
        begin
            sum_sat = sum_wide[SUM_W-1:0];
        end
        diff = DIFF_W'(err) - DIFF_W'(prev_error_reg);

        stage_next.err   = err;
        stage_next.sum   = sum_sat;
        stage_next.diff  = diff;
        stage_next.roll  = sensor.roll_trim;
        stage_next.pitch = sensor.pitch_trim;
        stage_next.clip  = sum_clip;
    end

    // Advance controller state on each accepted request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            error_sum_reg  <= '0;
            prev_error_reg <= '0;
        end
        else if (accept)
        begin
            error_sum_reg  <= sum_sat;
            prev_error_reg <= err;
        end
    end

    // Hold operands for the multiplier stages
    always_ff @(posedge clk)
    begin
        if (en.err)
        begin
            stage_reg <= stage_next;
        end
    end

    assign stage      = stage_reg;
    assign prev_error = prev_error_reg;

endmodule

>>> src/apmm_term_mult.sv
// ----------------------------------------------------------------------------
// apmm_term_mult
// One PID term: signed operand times unsigned Q16.24 gain, rounded back to
// Q16.16 (ties away from zero) and clamped to +-2^61. Three stages:
// magnitude, partial products, sum/round/clamp.
// ----------------------------------------------------------------------------
module apmm_term_mult (
    input  logic                                 clk,
    input  apmm_pkg::stage_en_t                  en,
    input  logic signed [apmm_pkg::MAG_W-1:0]    operand,
    input  logic        [apmm_pkg::GAIN_W-1:0]   gain,
    output logic signed [apmm_pkg::TERM_W-1:0]   term,
    output logic                                 clip
);
    import apmm_pkg::*;

    logic                     neg_mag_reg;
    logic [MAG_W-1:0]         mag_reg;
    logic [MAG_W-1:0]         mag_next;

    logic                     neg_prod_reg;
    logic [PP_W-1:0]          pp_hh_reg;
    logic [PP_W-1:0]          pp_hl_reg;
    logic [PP_W-1:0]          pp_lh_reg;
    logic [PP_W-1:0]          pp_ll_reg;

    logic signed [TERM_W-1:0] term_reg;
    logic signed [TERM_W-1:0] term_next;
    logic                     clip_reg;
    logic                     clip_next;

    logic [PROD_W-1:0]        prod;
    logic [QUO_W-1:0]         quo;
    logic [QUO_W-1:0]         quo_sat;
    logic signed [TERM_W-1:0] term_mag;

    // Take magnitude and sign
    assign mag_next = operand[MAG_W-1] ? (~unsigned'(operand) + MAG_W'(1))
                                       : unsigned'(operand);

    always_ff @(posedge clk)
    begin
        if (en.mag)
        begin
            neg_mag_reg <= operand[MAG_W-1];
            mag_reg     <= mag_next;
        end
    end

    // Split into four partial products
    always_ff @(posedge clk)
    begin
        if (en.prod)
        begin
            neg_prod_reg <= neg_mag_reg;
            pp_hh_reg    <= PP_W'(mag_reg[MAG_W-1:MAG_HALF]) * PP_W'(gain[GAIN_W-1:GAIN_HALF]);
            pp_hl_reg    <= PP_W'(mag_reg[MAG_W-1:MAG_HALF]) * PP_W'(gain[GAIN_HALF-1:0]);
            pp_lh_reg    <= PP_W'(mag_reg[MAG_HALF-1:0]) * PP_W'(gain[GAIN_W-1:GAIN_HALF]);
            pp_ll_reg    <= PP_W'(mag_reg[MAG_HALF-1:0]) * PP_W'(gain[GAIN_HALF-1:0]);
        end
    end

    // Sum, round to nearest, clamp and restore sign
    always_comb
    begin
        prod = (PROD_W'(pp_hh_reg) << (MAG_HALF + GAIN_HALF))
             + (PROD_W'(pp_hl_reg) << MAG_HALF)
             + (PROD_W'(pp_lh_reg) << GAIN_HALF)
             + PROD_W'(pp_ll_reg)
             + (PROD_W'(1) << (FRAC_SHIFT - 1));
        quo       = prod[PROD_W-1:FRAC_SHIFT];
        clip_next = (quo > TERM_LIM);
        quo_sat   = clip_next ? TERM_LIM : quo;
        term_mag  = signed'(quo_sat[TERM_W-1:0]);
        term_next = neg_prod_reg ? -term_mag : term_mag;
    end

    always_ff @(posedge clk)
    begin
        if (en.term)
        begin
            term_reg <= term_next;
            clip_reg <= clip_next;
        end
    end

    assign term = term_reg;
    assign clip = clip_reg;

endmodule

>>> src/apmm_mixer.sv
// ----------------------------------------------------------------------------
// apmm_mixer
// Sums the three PID terms into thrust and mixes thrust with the roll and
// pitch trims into four saturated motor commands. Carries the trims and the
// error-sum clip flag alongside the multiplier stages.
// ----------------------------------------------------------------------------
module apmm_mixer (
    input  logic                                 clk,
    input  apmm_pkg::stage_en_t                  en,
    input  apmm_pkg::err_out_t                   stage,
    input  logic signed [apmm_pkg::TERM_W-1:0]   term_p,
    input  logic signed [apmm_pkg::TERM_W-1:0]   term_i,
    input  logic signed [apmm_pkg::TERM_W-1:0]   term_d,
    input  logic        [2:0]                    term_clip,
    output apmm_pkg::motor_t                     motor
);
    import apmm_pkg::*;

    typedef struct packed {
        logic signed [DATA_W-1:0] roll;
        logic signed [DATA_W-1:0] pitch;
        logic                     clip;
    } trim_t;

    trim_t                      trim_mag_reg;
    trim_t                      trim_prod_reg;
    trim_t                      trim_term_reg;
    trim_t                      trim_thrust_reg;
    logic signed [THRUST_W-1:0] thrust_reg;
    motor_t                     motor_reg;
    motor_t                     motor_next;

    logic signed [MIX_W-1:0]    mix_a;
    logic signed [MIX_W-1:0]    mix_b;
    logic signed [MIX_W-1:0]    mix_c;
    logic signed [MIX_W-1:0]    mix_d;
    logic [DATA_W:0]            sat_a;
    logic [DATA_W:0]            sat_b;
    logic [DATA_W:0]            sat_c;
    logic [DATA_W:0]            sat_d;

    // Clamp to 32 bits; top bit of the result flags a clamp
    function automatic logic [DATA_W:0] sat_word(input logic signed [MIX_W-1:0] v);
        logic in_range;
        logic [DATA_W-1:0] val;
        in_range = (&v[MIX_W-1:DATA_W-1]) || !(|v[MIX_W-1:DATA_W-1]);
        if (in_range)
        begin
            val = v[DATA_W-1:0];
        end
        else if (v[MIX_W-1])
        begin
            val = {1'b1, {(DATA_W-1){1'b0}}};
        end
        else
        begin
            val = {1'b0, {(DATA_W-1){1'b1}}};
        end
        return {!in_range, val};
    endfunction

    // Delay trims alongside the multiplier pipeline
    always_ff @(posedge clk)
    begin
        if (en.mag)
        begin
            trim_mag_reg <= '{roll: stage.roll, pitch: stage.pitch, clip: stage.clip};
        end
        if (en.prod)
        begin
            trim_prod_reg <= trim_mag_reg;
        end
        if (en.term)
        begin
            trim_term_reg <= trim_prod_reg;
        end
    end

    // Sum the three terms
    always_ff @(posedge clk)
    begin
        if (en.thrust)
        begin
            thrust_reg      <= THRUST_W'(term_p) + THRUST_W'(term_i) + THRUST_W'(term_d);
            trim_thrust_reg <= '{roll:  trim_term_reg.roll,
                                 pitch: trim_term_reg.pitch,
                                 clip:  trim_term_reg.clip | (|term_clip)};
        end
    end

    // Mix and saturate each motor
    always_comb
    begin
        mix_a = MIX_W'(thrust_reg) + MIX_W'(trim_thrust_reg.roll) - MIX_W'(trim_thrust_reg.pitch);
        mix_b = MIX_W'(thrust_reg) - MIX_W'(trim_thrust_reg.roll) - MIX_W'(trim_thrust_reg.pitch);
        mix_c = MIX_W'(thrust_reg) - MIX_W'(trim_thrust_reg.roll) + MIX_W'(trim_thrust_reg.pitch);
        mix_d = MIX_W'(thrust_reg) + MIX_W'(trim_thrust_reg.roll) + MIX_W'(trim_thrust_reg.pitch);
        sat_a = sat_word(mix_a);
        sat_b = sat_word(mix_b);
        sat_c = sat_word(mix_c);
        sat_d = sat_word(mix_d);

        motor_next.motor_a = signed'(sat_a[DATA_W-1:0]);
        motor_next.motor_b = signed'(sat_b[DATA_W-1:0]);
        motor_next.motor_c = signed'(sat_c[DATA_W-1:0]);
        motor_next.motor_d = signed'(sat_d[DATA_W-1:0]);
        motor_next.clipped = trim_thrust_reg.clip | sat_a[DATA_W] | sat_b[DATA_W]
                           | sat_c[DATA_W] | sat_d[DATA_W];
    end

    always_ff @(posedge clk)
    begin
        if (en.mix)
        begin
            motor_reg <= motor_next;
        end
    end

    assign motor = motor_reg;

endmodule

>>> src/altitude_pid_motor_mixer_core.sv
// ----------------------------------------------------------------------------
// altitude_pid_motor_mixer_core
// Altitude PID controller with quadrotor motor mixer, six-stage pipeline.
//
//   channel  | direction | handshake                   | payload
//   ---------+-----------+-----------------------------+----------------------
//   sensor   | in        | sensor_valid / sensor_stall | sensor_t (4 x Q16.16)
//   motor    | out       | motor_valid / motor_stall   | motor_t (4 x Q16.16, clip)
//   cfg      | in        | cfg_wr_en                   | cfg_index, cfg_data
//
// One request per cycle while the output is not stalled; the rate is set by
// the error-sum and last-error update in the error stage, a loop through its
// own registers; products are split into 24x20 partial products.
// Reset clears pipeline valids and controller state and loads default gains.
// A stalled result holds the last stage; empty stages still fill, and
// sensor_stall rises only when all six stages hold data.
// ----------------------------------------------------------------------------
module altitude_pid_motor_mixer_core (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  sensor_valid,
    output logic                                  sensor_stall,
    input  apmm_pkg::sensor_t                     sensor,
    output logic                                  motor_valid,
    input  logic                                  motor_stall,
    output apmm_pkg::motor_t                      motor,
    input  logic                                  cfg_wr_en,
    input  logic [apmm_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [apmm_pkg::GAIN_W-1:0]           cfg_data
);
    import apmm_pkg::*;

    logic [NUM_STAGES-1:0] valid_reg;
    stage_en_t             en;
    logic                  accept;

    logic [GAIN_W-1:0]     prop_gain_reg;
    logic [GAIN_W-1:0]     integ_gain_dt_reg;
    logic [GAIN_W-1:0]     deriv_gain_dt_reg;

    err_out_t              stage;
    logic signed [ERR_W-1:0]  prev_error;
    logic signed [TERM_W-1:0] term_p;
    logic signed [TERM_W-1:0] term_i;
    logic signed [TERM_W-1:0] term_d;
    logic [2:0]               term_clip;

    // Advance each stage when it is empty or its successor advances
    always_comb
    begin
        en.mix    = !valid_reg[5] || !motor_stall;
        en.thrust = !valid_reg[4] || en.mix;
        en.term   = !valid_reg[3] || en.thrust;
        en.prod   = !valid_reg[2] || en.term;
        en.mag    = !valid_reg[1] || en.prod;
        en.err    = !valid_reg[0] || en.mag;
    end

    assign sensor_stall = !en.err;
    assign accept       = sensor_valid && en.err;
    assign motor_valid  = valid_reg[5];

    // Track stage occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (en.err)
            begin
                valid_reg[0] <= sensor_valid;
            end
            if (en.mag)
            begin
                valid_reg[1] <= valid_reg[0];
            end
            if (en.prod)
            begin
                valid_reg[2] <= valid_reg[1];
            end
            if (en.term)
            begin
                valid_reg[3] <= valid_reg[2];
            end
            if (en.thrust)
            begin
                valid_reg[4] <= valid_reg[3];
            end
            if (en.mix)
            begin
                valid_reg[5] <= valid_reg[4];
            end
        end
    end

    // Write gain registers; drop writes beyond the register list
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prop_gain_reg     <= PROP_GAIN_RST;
            integ_gain_dt_reg <= INTEG_GAIN_DT_RST;
            deriv_gain_dt_reg <= DERIV_GAIN_DT_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_PROP_GAIN:     prop_gain_reg     <= cfg_data;
                REG_INTEG_GAIN_DT: integ_gain_dt_reg <= cfg_data;
                REG_DERIV_GAIN_DT: deriv_gain_dt_reg <= cfg_data;
                default:           ;
            endcase
        end
    end

    apmm_err_stage u_err_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .accept     (accept),
        .sensor     (sensor),
        .stage      (stage),
        .prev_error (prev_error)
    );

    apmm_term_mult u_mult_p (
        .clk     (clk),
        .en      (en),
        .operand (MAG_W'(stage.err)),
        .gain    (prop_gain_reg),
        .term    (term_p),
        .clip    (term_clip[0])
    );

    apmm_term_mult u_mult_i (
        .clk     (clk),
        .en      (en),
        .operand (MAG_W'(stage.sum)),
        .gain    (integ_gain_dt_reg),
        .term    (term_i),
        .clip    (term_clip[1])
    );

    apmm_term_mult u_mult_d (
        .clk     (clk),
        .en      (en),
        .operand (MAG_W'(stage.diff)),
        .gain    (deriv_gain_dt_reg),
        .term    (term_d),
        .clip    (term_clip[2])
    );

    apmm_mixer u_mixer (
        .clk       (clk),
        .en        (en),
        .stage     (stage),
        .term_p    (term_p),
        .term_i    (term_i),
        .term_d    (term_d),
        .term_clip (term_clip),
        .motor     (motor)
    );

    // An accepted request enters the error stage
    a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> valid_reg[0])
        else $error("accepted request did not enter the error stage");

    // Last error tracks the error just registered for the accepted request
    a_prev_error: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (prev_error == stage.err))
        else $error("last error does not match the registered error");

    // Input is stalled only when every stage holds data
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        sensor_stall |-> (&valid_reg))
        else $error("input stalled with an empty pipeline stage");

endmodule

>>> test/tb_altitude_pid_motor_mixer_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_altitude_pid_motor_mixer_core
// Self-checking bench for the altitude PID and quadrotor motor mixer. A
// scoreboard predicts every motor request from each accepted sensor request,
// tracking the error sum, the last error and the gains on its own. Directed
// corner requests come first, then random traffic over several gain settings
// with random idle gaps and output stalls, and finally short climb and dive
// runs at full-scale error with the integral gain at its maximum.
// ----------------------------------------------------------------------------
module tb_altitude_pid_motor_mixer_core;

    import apmm_pkg::*;

    localparam int          PIPE_DEPTH  = 6;
    localparam int unsigned CYCLE_LIMIT = 800000;
    localparam int          PHASE_ITEMS = 90;
    localparam int          CLIMB_ITEMS = 40;
    localparam int          DIVE_ITEMS  = 50;

    // Index past the end of the register list; writes there are dropped
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    localparam logic [GAIN_W-1:0] GAIN_MAX = {GAIN_W{1'b1}};

    localparam logic signed [DATA_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] Q_MIN = 32'sh8000_0000;
    localparam int                       Q_ONE = 65536;

    localparam longint     ERR_SUM_HI = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint     ERR_SUM_LO = -64'sh0000_8000_0000_0000;
    localparam longint     MOTOR_HI   = 64'sh7FFF_FFFF;
    localparam longint     MOTOR_LO   = -64'sh8000_0000;
    localparam logic [127:0] TERM_CAP = 128'h1 << 61;

    typedef enum {TRAFFIC_MIXED, TRAFFIC_CLIMB, TRAFFIC_DIVE} traffic_t;

    // ------------------------------------------------------------------------
    // Scoreboard: altitude PID and mixer prediction, result comparison
    // ------------------------------------------------------------------------
    class motor_scoreboard;
        logic [GAIN_W-1:0] prop_gain;
        logic [GAIN_W-1:0] integ_gain;
        logic [GAIN_W-1:0] deriv_gain;
        longint            err_sum;
        longint            last_err;
        motor_t            pending_motors[$];
        int unsigned       mismatches;

        function new();
            prop_gain  = PROP_GAIN_RST;
            integ_gain = INTEG_GAIN_DT_RST;
            deriv_gain = DERIV_GAIN_DT_RST;
            err_sum    = 0;
            last_err   = 0;
            mismatches = 0;
        endfunction

        function void set_gain(logic [CFG_IDX_W-1:0] idx, logic [GAIN_W-1:0] val);
            case (idx)
                REG_PROP_GAIN:     prop_gain  = val;
                REG_INTEG_GAIN_DT: integ_gain = val;
                REG_DERIV_GAIN_DT: deriv_gain = val;
                default: ;
            endcase
        endfunction

        // Q16.16 times Q16.24, rounded half away from zero, capped at 2^61
        function longint scale_q24(longint a, logic [GAIN_W-1:0] g, inout bit clip);
            logic [127:0] mag;
            logic [127:0] quo;
            mag = (a < 0) ? 128'(-a) : 128'(a);
            quo = (mag * 128'(g) + 128'h80_0000) >> 24;
            if (quo > TERM_CAP)
            begin
                quo  = TERM_CAP;
                clip = 1'b1;
            end
            return (a < 0) ? -longint'(quo[63:0]) : longint'(quo[63:0]);
        endfunction

        function logic signed [DATA_W-1:0] clamp_motor(longint v, inout bit clip);
            if (v > MOTOR_HI)
            begin
                v    = MOTOR_HI;
                clip = 1'b1;
            end
            else if (v < MOTOR_LO)
            begin
                v    = MOTOR_LO;
                clip = 1'b1;
            end
            return v[DATA_W-1:0];
        endfunction

        // Advance the controller state and queue the expected motor request
        function void note_sensor(sensor_t s);
            longint err;
            longint sum;
            longint diff;
            longint p_term;
            longint i_term;
            longint d_term;
            longint thrust;
            longint roll;
            longint pitch;
            bit     clip;
            motor_t m;
            clip = 1'b0;
            err  = longint'($signed(s.target_z)) - longint'($signed(s.measured_z));
            sum  = err_sum + err;
            if (sum > ERR_SUM_HI)
            begin
                sum  = ERR_SUM_HI;
                clip = 1'b1;
            end
            else if (sum < ERR_SUM_LO)
            begin
                sum  = ERR_SUM_LO;
                clip = 1'b1;
            end
            err_sum  = sum;
            diff     = err - last_err;
            last_err = err;

            p_term = scale_q24(err, prop_gain, clip);
            i_term = scale_q24(sum, integ_gain, clip);
            d_term = scale_q24(diff, deriv_gain, clip);
            thrust = p_term + i_term + d_term;

            roll  = longint'($signed(s.roll_trim));
            pitch = longint'($signed(s.pitch_trim));
            m.motor_a = clamp_motor(thrust + roll - pitch, clip);
            m.motor_b = clamp_motor(thrust - roll - pitch, clip);
            m.motor_c = clamp_motor(thrust - roll + pitch, clip);
            m.motor_d = clamp_motor(thrust + roll + pitch, clip);
            m.clipped = clip;
            pending_motors.push_back(m);
        endfunction

        // Compare a motor request against the oldest prediction
        function void check_motor(motor_t got);
            motor_t want;
            if (pending_motors.size() == 0)
            begin
                if (mismatches < 10)
                    $display("motor request with no sensor request pending: a=%0d b=%0d",
                             got.motor_a, got.motor_b);
                mismatches++;
                return;
            end
            want = pending_motors.pop_front();
            if (got.motor_a !== want.motor_a || got.motor_b !== want.motor_b ||
                got.motor_c !== want.motor_c || got.motor_d !== want.motor_d ||
                got.clipped !== want.clipped)
            begin
                if (mismatches < 10)
                begin
                    $display("motor mismatch at %0t", $realtime);
                    $display("  expected a=%0d b=%0d c=%0d d=%0d clipped=%0b",
                             want.motor_a, want.motor_b, want.motor_c, want.motor_d,
                             want.clipped);
                    $display("  actual   a=%0d b=%0d c=%0d d=%0d clipped=%0b",
                             got.motor_a, got.motor_b, got.motor_c, got.motor_d,
                             got.clipped);
                end
                mismatches++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Signals and block instance
    // ------------------------------------------------------------------------
    logic                 clk          = 1'b0;
    logic                 rst_n        = 1'b0;
    logic                 sensor_valid = 1'b0;
    logic                 sensor_stall;
    sensor_t              sensor       = '0;
    logic                 motor_valid;
    logic                 motor_stall  = 1'b0;
    motor_t               motor;
    logic                 cfg_wr_en    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index    = '0;
    logic [GAIN_W-1:0]    cfg_data     = '0;

    motor_scoreboard sb = new();

    bit          sensor_idle_on = 1'b1;
    bit          motor_stall_on = 1'b1;
    int unsigned cycle_count    = 0;
    int          track_goal     = 0;
    int          track_alt      = 0;
    int          track_left     = 0;

    altitude_pid_motor_mixer_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .sensor_valid (sensor_valid),
        .sensor_stall (sensor_stall),
        .sensor       (sensor),
        .motor_valid  (motor_valid),
        .motor_stall  (motor_stall),
        .motor        (motor),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Monitors: note accepted sensor requests, check accepted motor requests
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && sensor_valid && !sensor_stall)
            sb.note_sensor(sensor);
        if (rst_n && motor_valid && !motor_stall)
            sb.check_motor(motor);
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Mostly short gaps, now and then a long one
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(11, 40);
    endfunction

    // Hold the output side off at random
    initial
    begin : motor_backpressure
        int hold;
        hold = 0;
        forever
        begin
            @(posedge clk);
            if (hold > 0)
                hold--;
            else if (motor_stall_on && $urandom_range(0, 2) == 0)
                hold = gap_len();
            motor_stall <= (hold > 0);
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    function automatic sensor_t pack_sensor(logic signed [DATA_W-1:0] meas,
                                            logic signed [DATA_W-1:0] goal,
                                            logic signed [DATA_W-1:0] roll,
                                            logic signed [DATA_W-1:0] pitch);
        sensor_t s;
        s.measured_z = meas;
        s.target_z   = goal;
        s.roll_trim  = roll;
        s.pitch_trim = pitch;
        return s;
    endfunction

    function automatic logic signed [DATA_W-1:0] wide_value();
        case ($urandom_range(0, 7))
            0:       return Q_MAX;
            1:       return Q_MIN;
            2:       return 0;
            3, 4:    return int'($urandom_range(0, 2**21)) - 2**20;
            default: return $urandom;
        endcase
    endfunction

    // Next sensor request: full-scale climb or dive, else altitude tracking runs mixed with raw noise
    function automatic sensor_t next_sensor(traffic_t kind);
        case (kind)
            TRAFFIC_CLIMB: return pack_sensor(Q_MIN, Q_MAX, wide_value(), wide_value());
            TRAFFIC_DIVE:  return pack_sensor(Q_MAX, Q_MIN, wide_value(), wide_value());
            default: ;
        endcase
        if ($urandom_range(0, 9) < 6)
        begin
            if (track_left == 0)
            begin
                track_goal = int'($urandom_range(0, 2**24)) - 2**23;
                track_left = $urandom_range(10, 40);
            end
            track_left--;
            track_alt = track_alt + (track_goal - track_alt) / 4 +
                        int'($urandom_range(0, 512)) - 256;
            return pack_sensor(track_alt, track_goal,
                               int'($urandom_range(0, 2**18)) - 2**17,
                               int'($urandom_range(0, 2**18)) - 2**17);
        end
        return pack_sensor(wide_value(), wide_value(), wide_value(), wide_value());
    endfunction

    // Drive one sensor request and hold it until accepted
    task automatic push_sensor(sensor_t s);
        int gap;
        sensor_valid <= 1'b1;
        sensor       <= s;
        @(posedge clk);
        while (sensor_stall)
            @(posedge clk);
        gap = sensor_idle_on ? gap_len() : 0;
        if (gap > 0)
        begin
            sensor_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic run_traffic(traffic_t kind, int count);
        repeat (count) push_sensor(next_sensor(kind));
        sensor_valid <= 1'b0;
    endtask

    // Wait out all outstanding motor requests and the pipeline tail
    task automatic settle();
        while (sb.pending_motors.size() != 0)
            @(posedge clk);
        repeat (PIPE_DEPTH + 2) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [GAIN_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        sb.set_gain(idx, val);
    endtask

    // Load all three gains, plus a write to the unused index that must be dropped
    task automatic program_gains(logic [GAIN_W-1:0] p, logic [GAIN_W-1:0] i,
                                 logic [GAIN_W-1:0] d);
        write_reg(REG_PROP_GAIN, p);
        write_reg(REG_UNUSED, {8'($urandom), 32'($urandom)});
        write_reg(REG_INTEG_GAIN_DT, i);
        write_reg(REG_DERIV_GAIN_DT, d);
        cfg_wr_en <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin : stimulus
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed corners at reset gains: rounding ties, extremes, trim limits
        push_sensor(pack_sensor(0, 0, 0, 0));
        push_sensor(pack_sensor(0, 1, 0, 0));
        push_sensor(pack_sensor(1, 0, 0, 0));
        push_sensor(pack_sensor(-1, -1, -1, 1));
        push_sensor(pack_sensor(0, Q_ONE, 0, 0));
        push_sensor(pack_sensor(0, Q_ONE, 0, 0));
        push_sensor(pack_sensor(2 * Q_ONE, -3 * Q_ONE, Q_ONE, -Q_ONE));
        push_sensor(pack_sensor(Q_MIN, Q_MAX, 0, 0));
        push_sensor(pack_sensor(Q_MAX, Q_MIN, 0, 0));
        push_sensor(pack_sensor(Q_MAX, Q_MAX, Q_MAX, Q_MIN));
        push_sensor(pack_sensor(Q_MIN, Q_MIN, Q_MIN, Q_MAX));
        push_sensor(pack_sensor(0, 0, Q_MAX, Q_MAX));
        push_sensor(pack_sensor(0, 0, Q_MIN, Q_MIN));
        push_sensor(pack_sensor(Q_MIN, Q_MAX, Q_MAX, Q_MAX));
        push_sensor(pack_sensor(Q_MAX, Q_MIN, Q_MIN, Q_MIN));
        push_sensor(pack_sensor(0, 0, 0, 0));
        sensor_valid <= 1'b0;

        // Random traffic over several gain settings and idle patterns
        for (int ph = 0; ph < 5; ph++)
        begin
            settle();
            case (ph)
                1: program_gains('0, '0, '0);
                2: program_gains(GAIN_MAX, GAIN_MAX, GAIN_MAX);
                3: program_gains(GAIN_W'($urandom_range(0, 2**28)),
                                 GAIN_W'($urandom_range(0, 2**18)),
                                 GAIN_W'($urandom_range(0, 32'h8000_0000)));
                4: program_gains({8'($urandom), 32'($urandom)},
                                 {8'($urandom), 32'($urandom)},
                                 {8'($urandom), 32'($urandom)});
                default: ;
            endcase
            sensor_idle_on = (ph != 1 && ph != 2);
            motor_stall_on = (ph != 2 && ph != 3);
            run_traffic(TRAFFIC_MIXED, PHASE_ITEMS);
        end

        // Push the error sum hard both ways with the integral gain at maximum
        settle();
        program_gains(PROP_GAIN_RST, GAIN_MAX, DERIV_GAIN_DT_RST);
        sensor_idle_on = 1'b0;
        motor_stall_on = 1'b0;
        run_traffic(TRAFFIC_CLIMB, CLIMB_ITEMS);
        run_traffic(TRAFFIC_DIVE, DIVE_ITEMS);

        settle();
        if (sb.mismatches == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

>>> filelist.f
src/apmm_pkg.sv
src/apmm_err_stage.sv
src/apmm_term_mult.sv
src/apmm_mixer.sv
src/altitude_pid_motor_mixer_core.sv
test/tb_altitude_pid_motor_mixer_core.sv
